// ===== rtl/qtl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtl_pkg
// Shared types and token codes for the query token lexer.
// ----------------------------------------------------------------------------
package qtl_pkg;

    localparam int POS_BITS_DEF = 16;
    localparam int MAX_RES      = 3;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [5:0] K_DOT    = 6'd16;
    localparam logic [5:0] K_BANG   = 6'd17;
    localparam logic [5:0] K_NE     = 6'd18;
    localparam logic [5:0] K_EQEQ   = 6'd19;
    localparam logic [5:0] K_LT     = 6'd20;
    localparam logic [5:0] K_LE     = 6'd21;
    localparam logic [5:0] K_GT     = 6'd22;
    localparam logic [5:0] K_GE     = 6'd23;
    localparam logic [5:0] K_OR     = 6'd24;
    localparam logic [5:0] K_OROR   = 6'd25;
    localparam logic [5:0] K_AND    = 6'd26;
    localparam logic [5:0] K_ANDAND = 6'd27;
    localparam logic [5:0] K_STRING = 6'd28;
    localparam logic [5:0] K_INT    = 6'd29;
    localparam logic [5:0] K_FLOAT  = 6'd30;
    localparam logic [5:0] K_IDENT  = 6'd31;
    localparam logic [5:0] K_PRIM   = 6'd32;
    localparam logic [5:0] K_KEY0   = 6'd33;
    localparam logic [5:0] K_EOF    = 6'd50;
    localparam logic [5:0] K_NONE   = 6'h3F;

    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_UNTERM   = 3'd1;
    localparam logic [2:0] E_STRAY    = 3'd2;
    localparam logic [2:0] E_BARE_EQ  = 3'd3;
    localparam logic [2:0] E_OVERFLOW = 3'd4;
    localparam logic [2:0] E_TOO_LONG = 3'd5;

    typedef struct packed {
        logic [5:0]         token_kind;
        logic [3:0]         prim_code;
        logic [15:0]        token_start;
        logic [15:0]        token_len;
        logic signed [31:0] int_value;
        logic [2:0]         error_code;
        logic               last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0]                  cnt;
        t_result [MAX_RES-1:0]       res;
    } t_burst;

endpackage

// ===== rtl/qtl_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtl_in_if
// Source character channel: one byte or an end marker per word.
// ----------------------------------------------------------------------------
interface qtl_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] ch;

    modport source (output valid, output req_type, output ch, input ready);
    modport sink   (input valid, input req_type, input ch, output ready);
endinterface

// ===== rtl/qtl_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtl_out_if
// Token channel: one token or error per word.
// ----------------------------------------------------------------------------
interface qtl_out_if;
    logic               valid;
    logic               ready;
    logic [5:0]         token_kind;
    logic [3:0]         prim_code;
    logic [15:0]        token_start;
    logic [15:0]        token_len;
    logic signed [31:0] int_value;
    logic [2:0]         error_code;
    logic               last_of_run;

    modport source (output valid, output token_kind, output prim_code, output token_start,
                    output token_len, output int_value, output error_code,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input prim_code, input token_start,
                    input token_len, input int_value, input error_code,
                    input last_of_run, output ready);
endinterface

// ===== rtl/qtl_lex.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtl_lex
// Lexer state and single-pass next-state/token logic for one character.
// ----------------------------------------------------------------------------
module qtl_lex #(
    parameter int POS_BITS = qtl_pkg::POS_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_acc,
    input  logic           i_req_type,
    input  logic [7:0]     i_ch,
    output qtl_pkg::t_burst o_burst
);

    typedef enum logic [2:0] {
        M_IDLE, M_PEND, M_STR, M_INT, M_INTDOT, M_FLT, M_WORD, M_ERR
    } t_mode;

    localparam logic [2:0] P_NONE = 3'd0;
    localparam logic [2:0] P_BANG = 3'd1;
    localparam logic [2:0] P_EQ   = 3'd2;
    localparam logic [2:0] P_LT   = 3'd3;
    localparam logic [2:0] P_GT   = 3'd4;
    localparam logic [2:0] P_OR   = 3'd5;
    localparam logic [2:0] P_AND  = 3'd6;

    localparam logic [POS_BITS-1:0] POS_LIMIT = '1;

    localparam logic [47:0] KW_TEXT [17] = '{
        "create", "delete", "insert", "append", {"read", 16'h0}, {"write", 8'h0},
        "remove", {"take", 16'h0}, {"file", 16'h0}, {"query", 8'h0},
        {"ofst", 16'h0}, {"len", 24'h0}, "struct", {"union", 8'h0},
        {"true", 16'h0}, {"false", 8'h0}, {"as", 32'h0}
    };
    localparam logic [2:0] KW_LEN [17] = '{
        3'd6, 3'd6, 3'd6, 3'd6, 3'd4, 3'd5, 3'd6, 3'd4, 3'd4, 3'd5, 3'd4, 3'd3,
        3'd6, 3'd5, 3'd4, 3'd5, 3'd2
    };
    localparam logic [23:0] PR_TEXT [10] = '{
        {"u8", 8'h0}, "u16", "u32", "u64", {"i8", 8'h0}, "i16", "i32", "i64",
        "f32", "f64"
    };

    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        begin
            unique case (c)
                "+": k = 6'd0;   "-": k = 6'd1;   "/": k = 6'd2;   "*": k = 6'd3;
                "~": k = 6'd4;   "^": k = 6'd5;   "%": k = 6'd6;   ";": k = 6'd7;
                ":": k = 6'd8;   "[": k = 6'd9;   "]": k = 6'd10;  "{": k = 6'd11;
                "}": k = 6'd12;  "(": k = 6'd13;  ")": k = 6'd14;  ",": k = 6'd15;
                ".": k = qtl_pkg::K_DOT;
                default: k = qtl_pkg::K_NONE;
            endcase
            return k;
        end
    endfunction

    function automatic logic [2:0] pend_of(input logic [7:0] c);
        logic [2:0] p;
        begin
            unique case (c)
                "!": p = P_BANG;  "=": p = P_EQ;  "<": p = P_LT;
                ">": p = P_GT;    "|": p = P_OR;  "&": p = P_AND;
                default: p = P_NONE;
            endcase
            return p;
        end
    endfunction

    function automatic logic [7:0] pend_second(input logic [2:0] p);
        logic [7:0] c;
        begin
            unique case (p)
                P_OR:    c = "|";
                P_AND:   c = "&";
                P_NONE:  c = 8'h00;
                default: c = "=";
            endcase
            return c;
        end
    endfunction

    function automatic logic [5:0] pend_pair(input logic [2:0] p);
        logic [5:0] k;
        begin
            unique case (p)
                P_BANG:  k = qtl_pkg::K_NE;
                P_EQ:    k = qtl_pkg::K_EQEQ;
                P_LT:    k = qtl_pkg::K_LE;
                P_GT:    k = qtl_pkg::K_GE;
                P_OR:    k = qtl_pkg::K_OROR;
                P_AND:   k = qtl_pkg::K_ANDAND;
                default: k = 6'd0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [5:0] pend_single(input logic [2:0] p);
        logic [5:0] k;
        begin
            unique case (p)
                P_BANG:  k = qtl_pkg::K_BANG;
                P_LT:    k = qtl_pkg::K_LT;
                P_GT:    k = qtl_pkg::K_GT;
                P_OR:    k = qtl_pkg::K_OR;
                P_AND:   k = qtl_pkg::K_AND;
                default: k = 6'd0;
            endcase
            return k;
        end
    endfunction

    // {kind, prim}; identifier when nothing matches
    function automatic logic [9:0] word_class(input logic [47:0] w, input logic [2:0] len);
        logic [47:0] mask;
        logic [9:0]  r;
        begin
            mask = ~(48'hFFFF_FFFF_FFFF >> {len, 3'b000});
            r    = {qtl_pkg::K_IDENT, 4'd0};
            for (int i = 16; i >= 0; i--) begin
                if (len == KW_LEN[i] && (w & mask) == KW_TEXT[i])
                    r = {6'(qtl_pkg::K_KEY0 + 6'(i)), 4'd0};
            end
            for (int i = 9; i >= 0; i--) begin
                if (len == ((i == 0 || i == 4) ? 3'd2 : 3'd3)
                    && (w & mask) == {PR_TEXT[i], 24'h0})
                    r = {qtl_pkg::K_PRIM, 4'(i)};
            end
            return r;
        end
    endfunction

    function automatic qtl_pkg::t_result mk(input logic [5:0] kind, input logic [3:0] prim,
                                            input logic [15:0] start, input logic [15:0] len,
                                            input logic [31:0] ival, input logic [2:0] err);
        qtl_pkg::t_result r;
        begin
            r.token_kind  = kind;
            r.prim_code   = prim;
            r.token_start = start;
            r.token_len   = len;
            r.int_value   = ival;
            r.error_code  = err;
            r.last_of_run = 1'b0;
            return r;
        end
    endfunction

    t_mode               r_mode, n_mode;
    logic [2:0]          r_pend, n_pend;
    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [POS_BITS-1:0] r_lst, n_lst;
    logic [30:0]         r_acc, n_acc;
    logic                r_ovf, n_ovf;
    logic [7:0]          r_wb [6];

    logic                wb_we;
    logic [2:0]          wb_idx;
    logic                is_dig, is_alp, is_ws, again;
    logic [3:0]          dig;
    logic [34:0]         prod;
    logic [POS_BITS-1:0] run_len, k_off;
    logic [9:0]          wcls;
    logic [5:0]          sk;
    logic [2:0]          pk;
    logic [1:0]          n;
    qtl_pkg::t_result [2:0] res;

    always_comb begin
        is_dig  = i_ch >= "0" && i_ch <= "9";
        is_alp  = (i_ch >= "a" && i_ch <= "z") || (i_ch >= "A" && i_ch <= "Z") || i_ch == "_";
        is_ws   = i_ch == 8'h20 || i_ch == 8'h09 || i_ch == 8'h0D || i_ch == 8'h0A;
        dig     = 4'(i_ch - "0");
        prod    = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + 35'(dig);
        run_len = r_pos - r_lst;
        k_off   = run_len;
        wcls    = word_class({r_wb[0], r_wb[1], r_wb[2], r_wb[3], r_wb[4], r_wb[5]},
                             run_len[2:0]);
        sk      = single_kind(i_ch);
        pk      = pend_of(i_ch);

        n_mode = r_mode;
        n_pend = r_pend;
        n_pos  = r_pos;
        n_lst  = r_lst;
        n_acc  = r_acc;
        n_ovf  = r_ovf;
        wb_we  = 1'b0;
        wb_idx = k_off[2:0];
        again  = 1'b0;
        n      = 2'd0;
        res    = '0;

        if (i_req_type) begin
            unique case (r_mode)
                M_PEND: begin
                    if (r_pend == P_EQ)
                        res[n] = mk(6'd0, 4'd0, 16'(r_lst), 16'd0, 32'd0, qtl_pkg::E_BARE_EQ);
                    else
                        res[n] = mk(pend_single(r_pend), 4'd0, 16'(r_lst), 16'd1, 32'd0,
                                    qtl_pkg::E_NONE);
                    n = n + 2'd1;
                end
                M_STR: begin
                    res[n] = mk(6'd0, 4'd0, 16'(r_lst), 16'd0, 32'd0, qtl_pkg::E_UNTERM);
                    n = n + 2'd1;
                end
                M_INT, M_INTDOT: begin
                    if (r_ovf)
                        res[n] = mk(6'd0, 4'd0, 16'(r_lst), 16'd0, 32'd0,
                                    qtl_pkg::E_OVERFLOW);
                    else
                        res[n] = mk(qtl_pkg::K_INT, 4'd0, 16'(r_lst),
                                    16'((r_mode == M_INTDOT) ? run_len - 1'b1 : run_len),
                                    {1'b0, r_acc}, qtl_pkg::E_NONE);
                    n = n + 2'd1;
                    if (r_mode == M_INTDOT && !r_ovf) begin
                        res[n] = mk(qtl_pkg::K_DOT, 4'd0, 16'(r_pos - 1'b1), 16'd1, 32'd0,
                                    qtl_pkg::E_NONE);
                        n = n + 2'd1;
                    end
                end
                M_FLT: begin
                    res[n] = mk(qtl_pkg::K_FLOAT, 4'd0, 16'(r_lst), 16'(run_len), 32'd0,
                                qtl_pkg::E_NONE);
                    n = n + 2'd1;
                end
                M_WORD: begin
                    if (run_len <= POS_BITS'(6))
                        res[n] = mk(wcls[9:4], wcls[3:0], 16'(r_lst), 16'(run_len), 32'd0,
                                    qtl_pkg::E_NONE);
                    else
                        res[n] = mk(qtl_pkg::K_IDENT, 4'd0, 16'(r_lst), 16'(run_len), 32'd0,
                                    qtl_pkg::E_NONE);
                    n = n + 2'd1;
                end
                default: ;
            endcase
            res[n] = mk(qtl_pkg::K_EOF, 4'd0, 16'(r_pos), 16'd0, 32'd0, qtl_pkg::E_NONE);
            n = n + 2'd1;
            n_mode = M_IDLE;
            n_pend = P_NONE;
            n_pos  = '0;
            n_lst  = '0;
            n_acc  = '0;
            n_ovf  = 1'b0;
        end else if (r_mode == M_ERR) begin
            n_mode = M_ERR;
        end else if (r_pos == POS_LIMIT) begin
            res[n] = mk(6'd0, 4'd0, 16'(r_pos), 16'd0, 32'd0, qtl_pkg::E_TOO_LONG);
            n = n + 2'd1;
            n_mode = M_ERR;
        end else begin
            again = 1'b1;
            unique case (r_mode)
                M_PEND: begin
                    if (i_ch == pend_second(r_pend)) begin
                        n_pos  = r_pos + 1'b1;
                        res[n] = mk(pend_pair(r_pend), 4'd0, 16'(r_lst), 16'd2, 32'd0,
                                    qtl_pkg::E_NONE);
                        n = n + 2'd1;
                        n_mode = M_IDLE;
                        again  = 1'b0;
                    end else if (r_pend == P_EQ) begin
                        res[n] = mk(6'd0, 4'd0, 16'(r_lst), 16'd0, 32'd0, qtl_pkg::E_BARE_EQ);
                        n = n + 2'd1;
                        n_mode = M_ERR;
                        again  = 1'b0;
                    end else begin
                        res[n] = mk(pend_single(r_pend), 4'd0, 16'(r_lst), 16'd1, 32'd0,
                                    qtl_pkg::E_NONE);
                        n = n + 2'd1;
                        n_mode = M_IDLE;
                    end
                end
                M_STR: begin
                    n_pos = r_pos + 1'b1;
                    if (i_ch == "\"") begin
                        res[n] = mk(qtl_pkg::K_STRING, 4'd0, 16'(r_lst), 16'(run_len + 1'b1),
                                    32'd0, qtl_pkg::E_NONE);
                        n = n + 2'd1;
                        n_mode = M_IDLE;
                    end
                    again = 1'b0;
                end
                M_INT: begin
                    if (is_dig) begin
                        if (!r_ovf) begin
                            if (prod > 35'd2147483647)
                                n_ovf = 1'b1;
                            else
                                n_acc = prod[30:0];
                        end
                        n_pos = r_pos + 1'b1;
                        again = 1'b0;
                    end else if (i_ch == ".") begin
                        n_pos  = r_pos + 1'b1;
                        n_mode = M_INTDOT;
                        again  = 1'b0;
                    end else if (r_ovf) begin
                        res[n] = mk(6'd0, 4'd0, 16'(r_lst), 16'd0, 32'd0,
                                    qtl_pkg::E_OVERFLOW);
                        n = n + 2'd1;
                        n_mode = M_ERR;
                        again  = 1'b0;
                    end else begin
                        res[n] = mk(qtl_pkg::K_INT, 4'd0, 16'(r_lst), 16'(run_len),
                                    {1'b0, r_acc}, qtl_pkg::E_NONE);
                        n = n + 2'd1;
                        n_mode = M_IDLE;
                    end
                end
                M_INTDOT: begin
                    if (is_dig) begin
                        n_pos  = r_pos + 1'b1;
                        n_mode = M_FLT;
                        again  = 1'b0;
                    end else if (r_ovf) begin
                        res[n] = mk(6'd0, 4'd0, 16'(r_lst), 16'd0, 32'd0,
                                    qtl_pkg::E_OVERFLOW);
                        n = n + 2'd1;
                        n_mode = M_ERR;
                        again  = 1'b0;
                    end else begin
                        res[n] = mk(qtl_pkg::K_INT, 4'd0, 16'(r_lst), 16'(run_len - 1'b1),
                                    {1'b0, r_acc}, qtl_pkg::E_NONE);
                        n = n + 2'd1;
                        res[n] = mk(qtl_pkg::K_DOT, 4'd0, 16'(r_pos - 1'b1), 16'd1, 32'd0,
                                    qtl_pkg::E_NONE);
                        n = n + 2'd1;
                        n_mode = M_IDLE;
                    end
                end
                M_FLT: begin
                    if (is_dig) begin
                        n_pos = r_pos + 1'b1;
                        again = 1'b0;
                    end else begin
                        res[n] = mk(qtl_pkg::K_FLOAT, 4'd0, 16'(r_lst), 16'(run_len), 32'd0,
                                    qtl_pkg::E_NONE);
                        n = n + 2'd1;
                        n_mode = M_IDLE;
                    end
                end
                M_WORD: begin
                    if (is_alp || is_dig) begin
                        wb_we = k_off < POS_BITS'(6);
                        n_pos = r_pos + 1'b1;
                        again = 1'b0;
                    end else begin
                        if (run_len <= POS_BITS'(6))
                            res[n] = mk(wcls[9:4], wcls[3:0], 16'(r_lst), 16'(run_len), 32'd0,
                                        qtl_pkg::E_NONE);
                        else
                            res[n] = mk(qtl_pkg::K_IDENT, 4'd0, 16'(r_lst), 16'(run_len),
                                        32'd0, qtl_pkg::E_NONE);
                        n = n + 2'd1;
                        n_mode = M_IDLE;
                    end
                end
                default: n_mode = M_IDLE;
            endcase

            // start of a fresh lexeme at the current character
            if (again) begin
                n_lst = r_pos;
                n_pos = r_pos + 1'b1;
                if (is_ws) begin
                    n_mode = M_IDLE;
                end else if (sk != qtl_pkg::K_NONE) begin
                    res[n] = mk(sk, 4'd0, 16'(r_pos), 16'd1, 32'd0, qtl_pkg::E_NONE);
                    n = n + 2'd1;
                end else if (pk != P_NONE) begin
                    n_pend = pk;
                    n_mode = M_PEND;
                end else if (i_ch == "\"") begin
                    n_mode = M_STR;
                end else if (is_dig) begin
                    n_acc  = 31'(dig);
                    n_ovf  = 1'b0;
                    n_mode = M_INT;
                end else if (is_alp) begin
                    wb_we  = 1'b1;
                    wb_idx = 3'd0;
                    n_mode = M_WORD;
                end else begin
                    res[n] = mk(6'd0, 4'd0, 16'(r_pos), 16'd0, 32'd0, qtl_pkg::E_STRAY);
                    n = n + 2'd1;
                    n_mode = M_ERR;
                end
            end
        end

        if (n != 2'd0)
            res[n - 2'd1].last_of_run = 1'b1;
        o_burst.cnt = n;
        o_burst.res = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_pend <= P_NONE;
            r_pos  <= '0;
            r_lst  <= '0;
            r_acc  <= '0;
            r_ovf  <= 1'b0;
        end else if (i_acc) begin
            r_mode <= n_mode;
            r_pend <= n_pend;
            r_pos  <= n_pos;
            r_lst  <= n_lst;
            r_acc  <= n_acc;
            r_ovf  <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc && wb_we)
            r_wb[wb_idx] <= i_ch;
    end

endmodule

// ===== rtl/query_token_lexer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_token_lexer_core
// Streaming query-language lexer: characters in, tokens out.
// ----------------------------------------------------------------------------
//  channel  | dir | word
//  i_src    | in  | req_type (char / end marker), ch
//  o_res    | out | kind, prim, start, len, int value, error, last_of_run
//
//  One character per cycle while i_src.ready is high; the lexer state updates
//  in the cycle of acceptance. Each character yields 0..3 tokens into a 4-word
//  queue; one token leaves per cycle while o_res.ready is high. i_src.ready is
//  high while at most one token is queued, so bursts of 2-3 tokens hold the input.
//  Synchronous active-low reset clears lexer state and the queue.
module query_token_lexer_core #(
    parameter int POS_BITS = qtl_pkg::POS_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    qtl_in_if.sink  i_src,
    qtl_out_if.source o_res
);

    localparam int QD = qtl_pkg::QUEUE_DEPTH;

    qtl_pkg::t_burst  burst;
    qtl_pkg::t_result r_q [QD];
    logic [1:0]       r_head;
    logic [2:0]       r_count, n_count;
    logic [1:0]       tail;
    logic             acc, deq;

    assign i_src.ready = r_count <= 3'd1;
    assign acc         = i_src.valid && i_src.ready;
    assign deq         = o_res.valid && o_res.ready;
    assign tail        = r_head + r_count[1:0];

    qtl_lex #(
        .POS_BITS (POS_BITS)
    ) u_lex (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_req_type (i_src.req_type),
        .i_ch       (i_src.ch),
        .o_burst    (burst)
    );

    always_comb begin
        n_count = r_count - {2'b0, deq};
        if (acc)
            n_count = n_count + {1'b0, burst.cnt};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (deq)
                r_head <= r_head + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < qtl_pkg::MAX_RES; j++) begin
            if (acc && 2'(j) < burst.cnt)
                r_q[2'(tail + 2'(j))] <= burst.res[j];
        end
    end

    assign o_res.valid       = r_count != 3'd0;
    assign o_res.token_kind  = r_q[r_head].token_kind;
    assign o_res.prim_code   = r_q[r_head].prim_code;
    assign o_res.token_start = r_q[r_head].token_start;
    assign o_res.token_len   = r_q[r_head].token_len;
    assign o_res.int_value   = r_q[r_head].int_value;
    assign o_res.error_code  = r_q[r_head].error_code;
    assign o_res.last_of_run = r_q[r_head].last_of_run;

`ifndef SYNTHESIS
    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(QD)) else $error("token queue overfilled");
    a_eof_emitted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_src.req_type |-> burst.cnt != 2'd0) else $error("end marker gave no token");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc && !deq |=> $stable(r_count)) else $error("queue count drifted");
    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && burst.cnt != 2'd0 |-> burst.res[burst.cnt - 2'd1].last_of_run)
        else $error("final token of a burst not marked");
`endif

endmodule

// ===== bench/tb_query_token_lexer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_query_token_lexer_core
// Self-checking bench for the query token lexer. A queue of source words
// (characters and end markers) feeds a driver with random idle bursts; each
// accepted word runs through a lexer model that queues the expected tokens.
// A monitor with random back-pressure checks every token against them.
// ----------------------------------------------------------------------------
module tb_query_token_lexer_core;

    typedef enum int {S_IDLE, S_PEND, S_STR, S_INT, S_INTDOT, S_FLT, S_WORD, S_ERR} t_scan;

    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_END  = 1'b1;
    localparam int   POS_MAX  = (1 << qtl_pkg::POS_BITS_DEF) - 1;

    logic i_clk;
    logic i_rst_n;

    qtl_in_if  src_if ();
    qtl_out_if res_if ();

    query_token_lexer_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_src  (src_if.sink),
        .o_res  (res_if.source)
    );

    // ---------------------------------------------------------------- model
    string   singles = "+-/*~^%;:[]{}(),.";
    string   pair_first = "!=<>|&";
    string   pair_second = "====|&";
    logic [5:0] pair_kind [6] = '{qtl_pkg::K_NE, qtl_pkg::K_EQEQ, qtl_pkg::K_LE,
                                  qtl_pkg::K_GE, qtl_pkg::K_OROR, qtl_pkg::K_ANDAND};
    logic [5:0] lone_kind [6] = '{qtl_pkg::K_BANG, qtl_pkg::K_NONE, qtl_pkg::K_LT,
                                  qtl_pkg::K_GT, qtl_pkg::K_OR, qtl_pkg::K_AND};
    string   prim_names [10] = '{"u8", "u16", "u32", "u64", "i8", "i16", "i32", "i64",
                                 "f32", "f64"};
    string   kw_names [17] = '{"create", "delete", "insert", "append", "read", "write",
                               "remove", "take", "file", "query", "ofst", "len", "struct",
                               "union", "true", "false", "as"};

    t_scan       scan;
    int          pend_idx;
    logic [31:0] pos;
    logic [31:0] lex_start;
    byte         wbuf [6];
    logic [31:0] acc;
    bit          ovf;

    qtl_pkg::t_result tokens_due [$];

    function automatic void lexer_clear();
        scan = S_IDLE; pend_idx = 0; pos = 0; lex_start = 0; acc = 0; ovf = 0;
    endfunction

    function automatic void emit(logic [5:0] kind, logic [3:0] prim, logic [31:0] start,
                                 logic [31:0] len, logic [31:0] ival, logic [2:0] err);
        qtl_pkg::t_result r;
        r.token_kind = kind; r.prim_code = prim; r.token_start = start[15:0];
        r.token_len = len[15:0]; r.int_value = ival; r.error_code = err;
        r.last_of_run = 1'b0;
        tokens_due.push_back(r);
    endfunction

    function automatic void fault(logic [31:0] start, logic [2:0] err);
        emit(6'd0, 4'd0, start, 0, 0, err);
        scan = S_ERR;
    endfunction

    function automatic bit is_dig(byte c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_let(byte c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit word_is(string t, int len);
        if (t.len() != len) return 0;
        for (int i = 0; i < len; i++)
            if (wbuf[i] != t[i]) return 0;
        return 1;
    endfunction

    function automatic bit close_int(logic [31:0] len);
        if (ovf) begin
            fault(lex_start, qtl_pkg::E_OVERFLOW);
            return 0;
        end
        emit(qtl_pkg::K_INT, 4'd0, lex_start, len, acc, qtl_pkg::E_NONE);
        scan = S_IDLE;
        return 1;
    endfunction

    function automatic void close_word();
        int len;
        len = pos - lex_start;
        scan = S_IDLE;
        if (len <= 6) begin
            for (int i = 0; i < 10; i++)
                if (word_is(prim_names[i], len)) begin
                    emit(qtl_pkg::K_PRIM, i[3:0], lex_start, len, 0, qtl_pkg::E_NONE);
                    return;
                end
            for (int i = 0; i < 17; i++)
                if (word_is(kw_names[i], len)) begin
                    emit(qtl_pkg::K_KEY0 + i[5:0], 4'd0, lex_start, len, 0,
                         qtl_pkg::E_NONE);
                    return;
                end
        end
        emit(qtl_pkg::K_IDENT, 4'd0, lex_start, len, 0, qtl_pkg::E_NONE);
    endfunction

    function automatic void start_lexeme(byte c);
        lex_start = pos;
        pos++;
        if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A) return;
        for (int i = 0; i < 17; i++)
            if (singles[i] == c) begin
                emit(i[5:0], 4'd0, lex_start, 1, 0, qtl_pkg::E_NONE);
                return;
            end
        for (int i = 0; i < 6; i++)
            if (pair_first[i] == c) begin
                pend_idx = i;
                scan = S_PEND;
                return;
            end
        if (c == "\"") scan = S_STR;
        else if (is_dig(c)) begin
            acc = c - "0"; ovf = 0; scan = S_INT;
        end else if (is_let(c)) begin
            wbuf[0] = c; scan = S_WORD;
        end else fault(lex_start, qtl_pkg::E_STRAY);
    endfunction

    function automatic void lex_word(logic req, byte c);
        int  n0;
        bit  again;
        logic [31:0] d;
        n0 = tokens_due.size();
        if (req == REQ_END) begin
            case (scan)
                S_PEND: if (lone_kind[pend_idx] == qtl_pkg::K_NONE)
                            fault(lex_start, qtl_pkg::E_BARE_EQ);
                        else emit(lone_kind[pend_idx], 4'd0, lex_start, 1, 0,
                                  qtl_pkg::E_NONE);
                S_STR:  fault(lex_start, qtl_pkg::E_UNTERM);
                S_INT:  void'(close_int(pos - lex_start));
                S_INTDOT: if (close_int(pos - 1 - lex_start))
                              emit(qtl_pkg::K_DOT, 4'd0, pos - 1, 1, 0, qtl_pkg::E_NONE);
                S_FLT:  emit(qtl_pkg::K_FLOAT, 4'd0, lex_start, pos - lex_start, 0,
                             qtl_pkg::E_NONE);
                S_WORD: close_word();
                default: ;
            endcase
            emit(qtl_pkg::K_EOF, 4'd0, pos, 0, 0, qtl_pkg::E_NONE);
            tokens_due[tokens_due.size()-1].last_of_run = 1'b1;
            lexer_clear();
            return;
        end
        if (scan == S_ERR) return;
        if (pos >= POS_MAX) fault(pos, qtl_pkg::E_TOO_LONG);
        else begin
            again = 1;
            case (scan)
                S_PEND: begin
                    if (c == pair_second[pend_idx]) begin
                        pos++;
                        emit(pair_kind[pend_idx], 4'd0, lex_start, 2, 0, qtl_pkg::E_NONE);
                        scan = S_IDLE; again = 0;
                    end else if (lone_kind[pend_idx] == qtl_pkg::K_NONE) begin
                        fault(lex_start, qtl_pkg::E_BARE_EQ); again = 0;
                    end else begin
                        emit(lone_kind[pend_idx], 4'd0, lex_start, 1, 0, qtl_pkg::E_NONE);
                        scan = S_IDLE;
                    end
                end
                S_STR: begin
                    pos++;
                    if (c == "\"") begin
                        emit(qtl_pkg::K_STRING, 4'd0, lex_start, pos - lex_start, 0,
                             qtl_pkg::E_NONE);
                        scan = S_IDLE;
                    end
                    again = 0;
                end
                S_INT: begin
                    if (is_dig(c)) begin
                        d = c - "0";
                        if (!ovf) begin
                            if (acc > (32'd2147483647 - d) / 10) ovf = 1;
                            else acc = acc * 10 + d;
                        end
                        pos++; again = 0;
                    end else if (c == ".") begin
                        pos++; scan = S_INTDOT; again = 0;
                    end else again = close_int(pos - lex_start);
                end
                S_INTDOT: begin
                    if (is_dig(c)) begin
                        pos++; scan = S_FLT; again = 0;
                    end else if (close_int(pos - 1 - lex_start))
                        emit(qtl_pkg::K_DOT, 4'd0, pos - 1, 1, 0, qtl_pkg::E_NONE);
                    else again = 0;
                end
                S_FLT: begin
                    if (is_dig(c)) begin
                        pos++; again = 0;
                    end else begin
                        emit(qtl_pkg::K_FLOAT, 4'd0, lex_start, pos - lex_start, 0,
                             qtl_pkg::E_NONE);
                        scan = S_IDLE;
                    end
                end
                S_WORD: begin
                    if (is_let(c) || is_dig(c)) begin
                        if (pos - lex_start < 6) wbuf[pos - lex_start] = c;
                        pos++; again = 0;
                    end else close_word();
                end
                default: scan = S_IDLE;
            endcase
            if (again) start_lexeme(c);
        end
        if (tokens_due.size() > n0) tokens_due[tokens_due.size()-1].last_of_run = 1'b1;
    endfunction

    // ------------------------------------------------------------ stimulus
    logic [8:0] words_pending [$];
    bit         quiet;
    int         fails;

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++) words_pending.push_back({REQ_CHAR, s[i]});
    endtask

    task automatic push_end();
        words_pending.push_back({REQ_END, 8'($urandom_range(0, 255))});
    endtask

    function automatic string rand_token();
        string s;
        case ($urandom_range(0, 11))
            0: s = kw_names[$urandom_range(0, 16)];
            1: s = prim_names[$urandom_range(0, 9)];
            2: s = $sformatf("_x%0d", $urandom_range(0, 999));
            3: s = $sformatf("%0d", $urandom());
            4: s = $sformatf("%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 99));
            5: s = $sformatf("%0d.", $urandom_range(0, 9));
            6: s = $sformatf("\"q%0d\"", $urandom_range(0, 99));
            7: s = "!=";
            8: begin s = " "; s[0] = singles[$urandom_range(0, 16)]; end
            9: begin s = "  "; s[0] = pair_first[$urandom_range(0, 5)];
                s[1] = ($urandom_range(0, 1)) ? pair_second[$urandom_range(0, 5)] : "a"; end
            10: s = "longidentifier9";
            default: s = "create_x";
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------- driver
    int src_gap;
    always @(posedge i_clk) begin
        logic [8:0] w;
        if (!i_rst_n) begin
            src_if.valid <= 1'b0;
            src_if.req_type <= REQ_CHAR;
            src_if.ch <= 8'd0;
            src_gap = 0;
        end else begin
            if (src_if.valid && src_if.ready) begin
                lex_word(src_if.req_type, src_if.ch);
                void'(words_pending.pop_front());
                if (!quiet && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 9);
            end
            if (src_gap > 0) begin
                src_gap--;
                src_if.valid <= 1'b0;
            end else if (words_pending.size() > 0) begin
                w = words_pending[0];
                src_if.valid <= 1'b1;
                src_if.req_type <= w[8];
                src_if.ch <= w[7:0];
            end else src_if.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------ monitor
    int res_gap;
    always @(posedge i_clk) begin
        qtl_pkg::t_result e;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            res_gap = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (tokens_due.size() == 0) begin
                    $error("token with none expected: kind %0d", res_if.token_kind);
                    fails++;
                end else begin
                    e = tokens_due.pop_front();
                    if (res_if.token_kind !== e.token_kind) begin
                        $error("token_kind exp %0d got %0d", e.token_kind, res_if.token_kind);
                        fails++;
                    end
                    if (res_if.prim_code !== e.prim_code) begin
                        $error("prim_code exp %0d got %0d", e.prim_code, res_if.prim_code);
                        fails++;
                    end
                    if (res_if.token_start !== e.token_start) begin
                        $error("token_start exp %0d got %0d", e.token_start, res_if.token_start);
                        fails++;
                    end
                    if (res_if.token_len !== e.token_len) begin
                        $error("token_len exp %0d got %0d", e.token_len, res_if.token_len);
                        fails++;
                    end
                    if (res_if.int_value !== e.int_value) begin
                        $error("int_value exp %0d got %0d", e.int_value, res_if.int_value);
                        fails++;
                    end
                    if (res_if.error_code !== e.error_code) begin
                        $error("error_code exp %0d got %0d", e.error_code, res_if.error_code);
                        fails++;
                    end
                    if (res_if.last_of_run !== e.last_of_run) begin
                        $error("last_of_run exp %0d got %0d", e.last_of_run,
                               res_if.last_of_run);
                        fails++;
                    end
                end
            end
            if (res_gap > 0) begin
                res_gap--;
                res_if.ready <= 1'b0;
            end else begin
                if (!quiet && $urandom_range(0, 7) == 0) res_gap = $urandom_range(1, 9);
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(4 * 1500000);
        $display("tb_query_token_lexer_core: errors");
        $finish;
    end

    initial begin
        int n;
        string s;
        fails = 0;
        quiet = 0;
        lexer_clear();
        i_rst_n = 1'b0;
        src_if.valid = 1'b0;
        src_if.req_type = REQ_CHAR;
        src_if.ch = 8'd0;
        res_if.ready = 1'b0;

        // directed: all operators, numbers at the overflow edge, int then bare dot
        push_text("+-/*~^%;:[]{}(),.! != == < <= > >= | || & &&");
        push_end();
        push_text("2147483647 2147483648 12.5 7.x u64 f32 struct as abcdefgh \"s\t\"");
        push_end();
        push_text("=x"); push_end();          // bare equals
        push_text("@ a b"); push_end();       // stray char, rest ignored
        push_text("\"open"); push_end();      // unterminated string
        push_text("="); push_end();
        push_text("<"); push_end();
        push_text("9."); push_end();
        push_text("99999999999."); push_end();
        words_pending.push_back({REQ_CHAR, 8'hFF}); push_end();

        // random: mostly well-formed token streams, some noise
        n = 0;
        while (n < 16) begin
            if ($urandom_range(0, 9) == 0) begin
                words_pending.push_back({REQ_CHAR, 8'($urandom_range(0, 255))});
                n++;
            end else begin
                s = rand_token();
                push_text(s);
                n += s.len();
                if ($urandom_range(0, 2) == 0) begin
                    push_text(" "); n++;
                end
            end
            if ($urandom_range(0, 14) == 0) begin
                push_end(); n++;
            end
        end
        push_end();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (words_pending.size() < 40);
        quiet = 1;
        wait (words_pending.size() == 0);
        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fails == 0 && tokens_due.size() == 0)
            $display("tb_query_token_lexer_core: clean");
        else
            $display("tb_query_token_lexer_core: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/qtl_pkg.sv
rtl/qtl_in_if.sv
rtl/qtl_out_if.sv
rtl/qtl_lex.sv
rtl/query_token_lexer_core.sv
bench/tb_query_token_lexer_core.sv
